[rtl/core/mhs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mhs_pkg;
  localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
  localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;
  localparam logic [63:0] SEED_RESET = 64'h00000000DEADBEEF;
  localparam logic [63:0] KEY_LEN = 64'd8;

  // slots per level; the index is the low hash bits, so keep a power of two
  localparam int BUCKETS = 256;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_DEL = 2'd1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL   = 12'b000000000010,
    S_MULHI = 12'b000000000100,
    S_MULLO = 12'b000000001000,
    S_MULFX = 12'b000000010000,
    S_RD    = 12'b000000100000,
    S_CHK   = 12'b000001000000,
    S_SHRD  = 12'b000010000000,
    S_SHWR  = 12'b000100000000,
    S_CLR   = 12'b001000000000,
    S_OUT   = 12'b010000000000,
    S_INIT  = 12'b100000000000
  } state_t;
endpackage
`default_nettype wire

[rtl/core/multilevel_hash_set_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Multilevel hash set of 64-bit keys.
// Input channel (in_valid/in_ready) carries cmd and key; cmd 0 adds, 1 deletes,
// 2 or 3 finds. Output channel (out_valid/out_ready) returns status and found,
// one result for every input transfer, held until taken.
// The key hash is XXH64 over the 8 key bytes, seeded by seed. The user must
// write seed through cfg_we/cfg_data only while the block is idle; the block
// itself does not enforce this.
// Flow: the hash runs five 64x64 multiplies on one shared 32x32 multiplier,
// each as three partial products (S_MUL, S_MULHI, S_MULLO) and one fold
// (S_MULFX); each level walked then takes a read and a check state, a delete
// shifts each later level with a read and a write state plus one clear,
// and S_OUT raises out_valid. One item is in flight at a time, so in_ready
// is low meanwhile. Reset loads the seed default and then clears the
// LEVELS*BUCKETS valid bits, one per cycle, with in_ready low; stored
// hashes and keys are undefined until written.
// While the receiver stalls the result is held and no new item is taken.
module multilevel_hash_set_core import mhs_pkg::*; #(
  parameter int LEVELS  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic             found
);
  localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SLOTS = LEVELS * BUCKETS;
  localparam int AW = $clog2(SLOTS);
  localparam logic [LW:0] LAST = (LW + 1)'(LEVELS - 1);

  state_t state;
  logic [63:0] seed;
  logic [1:0]  cmd_r;
  logic [63:0] key_r, h, mop_a, mop_b, acc;
  logic [2:0]  op;
  logic [1:0]  part;
  logic [IW-1:0] idx;
  logic [LW:0] lvl;
  logic        mem_v [SLOTS];
  logic [63:0] mem_h [SLOTS];
  logic [63:0] mem_k [SLOTS];
  logic        rd_v;
  logic [63:0] rd_h, rd_k;
  logic [AW-1:0] raddr, waddr, clr_addr;
  logic we;
  logic        wd_v;
  logic [63:0] wd_h, wd_k;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  // shared 32x32 multiplier
  assign prod = 64'(ma) * 64'(mb);
  always_comb begin
    unique case (part)
      2'd0: begin ma = mop_a[31:0];  mb = mop_b[31:0];  end
      2'd1: begin ma = mop_a[63:32]; mb = mop_b[31:0];  end
      2'd2: begin ma = mop_a[31:0];  mb = mop_b[63:32]; end
      default: begin ma = mop_a[63:32]; mb = mop_b[63:32]; end
    endcase
  end

  function automatic logic [63:0] rotl(input logic [63:0] v, input int r);
    rotl = (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [LW:0] l,
                                              input logic [IW-1:0] i);
    slot_addr = AW'(32'(l) * 32'(BUCKETS) + 32'(i));
  endfunction

  assign in_ready = (state == S_IDLE) && !out_valid;

  // memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_v[waddr] <= wd_v;
      mem_h[waddr] <= wd_h;
      mem_k[waddr] <= wd_k;
    end
    rd_v <= mem_v[raddr];
    rd_h <= mem_h[raddr];
    rd_k <= mem_k[raddr];
  end

  always_comb begin
    raddr = slot_addr(lvl, idx);
    if (state == S_SHRD) raddr = slot_addr(lvl + 1'b1, idx);
    waddr = slot_addr(lvl, idx);
    we = 1'b0;
    wd_v = 1'b1;
    wd_h = h;
    wd_k = key_r;
    if (state == S_CHK && cmd_r == CMD_ADD && !rd_v) we = 1'b1;
    if (state == S_SHWR) begin
      we = 1'b1; wd_v = rd_v; wd_h = rd_h; wd_k = rd_k;
    end
    // drop the last level's copy after a delete
    if (state == S_CLR) begin
      we = 1'b1; wd_v = 1'b0; waddr = slot_addr(LAST, idx);
    end
    // clear one valid bit per cycle after reset
    if (state == S_INIT) begin
      we = 1'b1; wd_v = 1'b0; waddr = clr_addr;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      seed <= SEED_RESET;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) seed <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          cmd_r <= cmd; key_r <= key;
          h <= seed + XP5 + KEY_LEN;
          mop_a <= key; mop_b <= XP2;
          op <= 3'd0; part <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          acc <= prod; part <= 2'd1; state <= S_MULHI;
        end
        S_MULHI: begin
          acc <= acc + {prod[31:0], 32'd0}; part <= 2'd2; state <= S_MULLO;
        end
        S_MULLO: begin
          acc <= acc + {prod[31:0], 32'd0}; part <= 2'd0; state <= S_MULFX;
        end
        S_MULFX: begin
          // acc holds the 64-bit product; apply the next hash step
          unique case (op)
            3'd0: begin mop_a <= rotl(acc, 31); mop_b <= XP1; end
            3'd1: begin mop_a <= rotl(h ^ acc, 27); mop_b <= XP1; end
            3'd2: begin
              mop_a <= (acc + XP4) ^ ((acc + XP4) >> 33); mop_b <= XP2;
            end
            3'd3: begin mop_a <= acc ^ (acc >> 29); mop_b <= XP3; end
            default: begin
              h <= acc ^ (acc >> 32);
              idx <= IW'(acc ^ (acc >> 32));
            end
          endcase
          op <= op + 3'd1;
          if (op == 3'd4) begin
            lvl <= '0; state <= S_RD;
          end else state <= S_MUL;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (!rd_v) begin
            found <= 1'b0;
            if (cmd_r == CMD_ADD) status <= ST_OK;
            else status <= ST_MISS;
            state <= S_OUT;
          end else if (rd_h == h && rd_k == key_r) begin
            found <= 1'b1;
            status <= (cmd_r == CMD_ADD) ? ST_MISS : ST_OK;
            if (cmd_r == CMD_DEL) state <= (lvl == LAST) ? S_CLR : S_SHRD;
            else state <= S_OUT;
          end else if (lvl == LAST) begin
            found <= 1'b0;
            status <= (cmd_r == CMD_ADD) ? ST_FULL : ST_MISS;
            state <= S_OUT;
          end else begin
            lvl <= lvl + 1'b1; state <= S_RD;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          lvl <= lvl + 1'b1;
          state <= (lvl + 1'b1 == LAST) ? S_CLR : S_SHRD;
        end
        S_CLR: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> !found) else $error("full with hit");
`endif
endmodule
`default_nettype wire

[verif/mhs_checker.sv]
`timescale 1ns / 1ps
module mhs_checker import mhs_pkg::*; #(
  parameter int BUCKETS = 256,
  parameter int LEVELS  = 4
) (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [63:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  cmd,
  input logic [63:0] key,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        found,
  output int         fail_count,
  output int         pending
);
  typedef struct packed {
    logic [1:0] status;
    logic       found;
  } result_t;

  localparam int NSLOT = LEVELS * BUCKETS;

  logic [63:0] seed;
  logic        set_valid [NSLOT];
  logic [63:0] set_hash [NSLOT];
  logic [63:0] set_key [NSLOT];
  result_t     expected_results [$];

  function automatic logic [63:0] rotl(logic [63:0] v, int r);
    return (v << r) | (v >> (64 - r));
  endfunction

  // XXH64 of a single 8-byte lane
  function automatic logic [63:0] xxh64_key(logic [63:0] k_in, logic [63:0] s);
    logic [63:0] h;
    logic [63:0] k;
    h = s + XP5 + 64'd8;
    k = k_in * XP2;
    k = rotl(k, 31) * XP1;
    h = h ^ k;
    h = rotl(h, 27) * XP1 + XP4;
    h = h ^ (h >> 33);
    h = h * XP2;
    h = h ^ (h >> 29);
    h = h * XP3;
    h = h ^ (h >> 32);
    return h;
  endfunction

  // Walk the levels at the key's index and apply the command
  function automatic result_t apply_set_op(logic [1:0] op, logic [63:0] k);
    logic [63:0] h;
    int idx;
    int hit;
    int empty;
    int a;
    result_t r;
    h = xxh64_key(k, seed);
    idx = int'(h % BUCKETS);
    hit = -1;
    empty = -1;
    for (int lv = 0; lv < LEVELS; lv++) begin
      a = lv * BUCKETS + idx;
      if (!set_valid[a]) begin
        empty = lv;
        break;
      end
      if (set_hash[a] == h && set_key[a] == k) begin
        hit = lv;
        break;
      end
    end
    r.found = (hit >= 0);
    if (op == CMD_ADD) begin
      if (hit >= 0) r.status = ST_MISS;
      else if (empty >= 0) begin
        a = empty * BUCKETS + idx;
        set_valid[a] = 1'b1;
        set_hash[a] = h;
        set_key[a] = k;
        r.status = ST_OK;
      end else r.status = ST_FULL;
    end else if (op == CMD_DEL) begin
      if (hit >= 0) begin
        for (int lv = hit; lv + 1 < LEVELS; lv++) begin
          a = lv * BUCKETS + idx;
          set_valid[a] = set_valid[a + BUCKETS];
          set_hash[a] = set_hash[a + BUCKETS];
          set_key[a] = set_key[a + BUCKETS];
        end
        set_valid[(LEVELS - 1) * BUCKETS + idx] = 1'b0;
        r.status = ST_OK;
      end else r.status = ST_MISS;
    end else begin
      r.status = (hit >= 0) ? ST_OK : ST_MISS;
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      seed <= SEED_RESET;
      for (int i = 0; i < NSLOT; i++) set_valid[i] = 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // Check a result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: unexpected result status=%0d found=%0d", status, found);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.status !== status || exp_r.found !== found) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: status exp %0d got %0d, found exp %0d got %0d",
                       exp_r.status, status, exp_r.found, found);
          end
        end
      end
      // Predict on each command transfer
      if (in_valid && in_ready) expected_results.push_back(apply_set_op(cmd, key));
      if (cfg_we) seed <= cfg_data;
    end
  end
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb import mhs_pkg::*;;
  localparam int LEVELS  = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = '0;
  logic [63:0] key = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        found;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  logic [63:0] key_pool [32];

  always #5 clk = ~clk;

  multilevel_hash_set_core #(.LEVELS(LEVELS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .key(key),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .found(found)
  );

  mhs_checker #(.BUCKETS(BUCKETS), .LEVELS(LEVELS)) checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .key(key),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .found(found),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Drive one command and hold it until the transfer
  task automatic send_cmd(logic [1:0] c, logic [63:0] k, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    cmd <= c;
    key <= k;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until idle, then write the seed
  task automatic write_seed(logic [63:0] v);
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random receiver stall, with quiet stretches
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if ($urandom_range(0, 299) < 30) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 60) ? 1'b1 : (gap_len() == 0);
  end

  // Watchdog on lack of progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (pending == 0 && !in_valid))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [1:0] c;
    logic [63:0] k;
    int p;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes and each command, find as both 2 and 3
    send_cmd(CMD_ADD, 64'h0, 1'b0);
    send_cmd(CMD_ADD, 64'h0, 1'b0);
    send_cmd(2'd2, 64'h0, 1'b0);
    send_cmd(2'd3, 64'h0, 1'b0);
    send_cmd(CMD_ADD, '1, 1'b0);
    send_cmd(2'd2, '1, 1'b0);
    send_cmd(CMD_DEL, 64'h0, 1'b0);
    send_cmd(CMD_DEL, 64'h0, 1'b0);
    send_cmd(2'd3, '1, 1'b0);
    send_cmd(CMD_DEL, '1, 1'b0);
    send_cmd(2'd2, 64'h5555_AAAA_5555_AAAA, 1'b0);

    // Phases over several seeds; small key pools force repeated keys, and phase 2 fills one index
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_seed(64'h0);
        1: write_seed('1);
        2: write_seed(rand64());
        3: write_seed(SEED_RESET);
        default: write_seed(rand64());
      endcase
      for (int i = 0; i < 32; i++) key_pool[i] = rand64();
      for (int n = 0; n < 330; n++) begin
        p = $urandom_range(0, 99);
        k = (p < 80) ? key_pool[$urandom_range(0, 31)] : rand64();
        p = $urandom_range(0, 99);
        c = (p < 45) ? CMD_ADD : (p < 70) ? CMD_DEL : (p < 95) ? 2'd2 : 2'd3;
        send_cmd(c, k, 1'b1);
      end
      // Fill one index past LEVELS by brute-force search of colliding keys
      if (ph == 2) begin
        int hits;
        logic [63:0] s;
        hits = 0;
        s = rand64();
        for (int t = 0; t < 100000 && hits < LEVELS + 1; t++) begin
          if ((checker_i.xxh64_key(s + t, checker_i.seed) % BUCKETS) == 7) begin
            send_cmd(CMD_ADD, s + t, 1'b0);
            hits++;
          end
        end
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

[sim.f]
rtl/core/mhs_pkg.sv
rtl/core/multilevel_hash_set_core.sv
verif/mhs_checker.sv
verif/tb.sv
